FILE: design/pipe_busy_trace_interval_decoder_defines.svh
// assertion macros for the pipe busy trace interval decoder
`ifndef PIPE_BUSY_TRACE_INTERVAL_DECODER_DEFINES_SVH
`define PIPE_BUSY_TRACE_INTERVAL_DECODER_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define PBTID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbtid check failed");
// next-cycle implication
`define PBTID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbtid check failed");
`else
`define PBTID_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PBTID_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/pbtid_pkg.sv
// shared types and constants of the pipe busy trace interval decoder
package pbtid_pkg;

    localparam int CHAN_W = 10;
    localparam int PIPE_W = 4;

    localparam logic [3:0]  TYPE_BUSY     = 4'hF;
    localparam logic [3:0]  TYPE_MARK_MAX = 4'd5;
    localparam logic [3:0]  TYPE_MARK_ALT = 4'd10;
    localparam logic [11:0] END_FIRST_ID  = 12'h888;
    localparam logic        KIND_INTERVAL = 1'b0;
    localparam logic        KIND_MARK     = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [5:0]  channel;
        logic [3:0]  pipe_or_type;
        logic [11:0] mark_id;
        logic [63:0] start_time;
        logic [63:0] duration;
        logic        end_run_open;
        logic        last;
    } res_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic clk_rd;
        logic clk_upd;
        logic mark_emit;
        logic p_rst;
        logic p_rd;
        logic p_eval;
        logic p_inc;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic busy_ok;
        logic mark_ok;
        logic p_last;
        logic need_emit;
        logic pend_valid;
        logic out_free;
    } sts_t;

endpackage

FILE: design/pbtid_ctrl.sv
// control state machine of the pipe busy trace interval decoder
module pbtid_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  pbtid_pkg::sts_t sts,
    output pbtid_pkg::cmd_t cmd
);
    import pbtid_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_CLK_RD = 7'b0000100,
        S_CLK_UP = 7'b0001000,
        S_P_RD   = 7'b0010000,
        S_P_EV   = 7'b0100000,
        S_FLUSH  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CLK_RD;
                end
            end
            S_CLK_RD:
            begin
                if (sts.busy_ok || sts.mark_ok)
                begin
                    cmd.clk_rd = 1'b1;
                    state_next = S_CLK_UP;
                end
                else
                    state_next = S_IDLE;
            end
            S_CLK_UP:
            begin
                if (sts.busy_ok)
                begin
                    cmd.clk_upd = 1'b1;
                    cmd.p_rst = 1'b1;
                    state_next = S_P_RD;
                end
                else if (sts.out_free)
                begin
                    cmd.clk_upd = 1'b1;
                    cmd.mark_emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_P_RD:
            begin
                cmd.p_rd = 1'b1;
                state_next = S_P_EV;
            end
            S_P_EV:
            begin
                if (!(sts.need_emit && sts.pend_valid && !sts.out_free))
                begin
                    cmd.p_eval = 1'b1;
                    if (sts.p_last)
                        state_next = S_FLUSH;
                    else
                    begin
                        cmd.p_inc = 1'b1;
                        state_next = S_P_RD;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!sts.pend_valid)
                    state_next = S_IDLE;
                else if (sts.out_free)
                begin
                    cmd.flush = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

FILE: design/pbtid_dp.sv
// datapath of the pipe busy trace interval decoder: memories, clocks, result registers
module pbtid_dp #(
    parameter int CHANNELS   = 64,
    parameter int PIPES      = 12,
    parameter int CORE_TYPES = 3
) (
    input  logic            clk,
    input  logic            rst_n,
    input  pbtid_pkg::cmd_t cmd,
    output pbtid_pkg::sts_t sts,
    input  logic [7:0]      core_id,
    input  logic [1:0]      core_type,
    input  logic [15:0]     info_word,
    input  logic [31:0]     cycle_delta,
    input  logic            out_stall,
    output logic            out_valid,
    output pbtid_pkg::res_t out_res
);
    import pbtid_pkg::*;

    localparam int DEPTH = CHANNELS * PIPES;
    localparam int CW    = $clog2(CHANNELS);
    localparam int PW    = $clog2(DEPTH);

    // record fields
    logic [CHAN_W-1:0] chan_reg;
    logic [1:0]        ctype_reg;
    logic [15:0]       info_reg;
    logic [31:0]       delta_reg;
    logic [PW-1:0]     base_reg;
    logic [CW-1:0]     chan_idx;
    logic [CHAN_W-1:0] chan_in;

    // memories and counters
    logic [63:0]       cmem [CHANNELS];
    logic [63:0]       pmem [DEPTH];
    logic [63:0]       c_rdata_reg;
    logic [63:0]       p_rdata_reg;
    logic [63:0]       clk_reg;
    logic [63:0]       clk_new;
    logic [PW-1:0]     clr_cnt_reg;
    logic [PW-1:0]     p_addr;
    logic [PIPE_W-1:0] p_reg;
    logic              end_open_reg [CHANNELS];
    logic              eo_rdata_reg;

    // results
    res_t  out_reg;
    res_t  out_data;
    logic  out_load;
    logic  out_valid_reg;
    logic  out_valid_next;
    res_t  pend_reg;
    logic  pend_valid_reg;
    logic  pend_valid_next;
    res_t  iv_res;
    res_t  mk_res;

    // evaluation
    logic [3:0]  rtype;
    logic [11:0] low;
    logic        is_end;
    logic        eopen_new;
    logic        bit_busy;
    logic        close_iv;
    logic        open_iv;
    logic        out_free;

    assign chan_in  = CHAN_W'(core_id) * CHAN_W'(3) + CHAN_W'(core_type);
    assign chan_idx = chan_reg[CW-1:0];
    assign rtype    = info_reg[15:12];
    assign low      = info_reg[11:0];
    assign clk_new  = c_rdata_reg + 64'(delta_reg);
    assign p_addr   = base_reg + PW'(p_reg);

    // capture the record
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            chan_reg  <= chan_in;
            ctype_reg <= core_type;
            info_reg  <= info_word;
            delta_reg <= cycle_delta;
            base_reg  <= PW'(32'(chan_in) * PIPES);
        end
    end

    // clearing pass counter and pipe counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            p_reg <= '0;
        end
        else
        begin
            if (cmd.clr)
                clr_cnt_reg <= clr_cnt_reg + PW'(1);
            if (cmd.p_rst)
                p_reg <= '0;
            else if (cmd.p_inc)
                p_reg <= p_reg + PIPE_W'(1);
        end
    end

    // channel clock memory
    always_ff @(posedge clk)
    begin
        if (cmd.clr && (32'(clr_cnt_reg) < CHANNELS))
            cmem[clr_cnt_reg[CW-1:0]] <= '0;
        else if (cmd.clk_upd)
            cmem[chan_idx] <= clk_new;
        if (cmd.clk_rd)
            c_rdata_reg <= cmem[chan_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clk_upd)
            clk_reg <= clk_new;
    end

    // pipe start memory
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
            pmem[clr_cnt_reg] <= '0;
        else if (cmd.p_eval && close_iv)
            pmem[p_addr] <= '0;
        else if (cmd.p_eval && open_iv)
            pmem[p_addr] <= clk_reg;
        if (cmd.p_rd)
            p_rdata_reg <= pmem[p_addr];
    end

    // end-marker run tracking
    assign is_end = low[11] && (low[3:0] == low[7:4]) && (low[7:4] == low[11:8]);
    always_comb
    begin
        if (!is_end)
            eopen_new = 1'b0;
        else if (low == END_FIRST_ID)
            eopen_new = 1'b1;
        else
            eopen_new = eo_rdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                end_open_reg[i] <= 1'b0;
        end
        else if (cmd.mark_emit)
            end_open_reg[chan_idx] <= eopen_new;
    end

    // run state read alongside the channel clock
    always_ff @(posedge clk)
    begin
        if (cmd.clk_rd)
            eo_rdata_reg <= end_open_reg[chan_idx];
    end

    // pipe evaluation
    assign bit_busy = low[p_reg];
    assign close_iv = !bit_busy && (p_rdata_reg != '0);
    assign open_iv  = bit_busy && (p_rdata_reg == '0);

    always_comb
    begin
        iv_res = '0;
        iv_res.kind         = KIND_INTERVAL;
        iv_res.channel      = chan_reg[5:0];
        iv_res.pipe_or_type = p_reg;
        iv_res.start_time   = p_rdata_reg;
        iv_res.duration     = clk_reg - p_rdata_reg;
        mk_res = '0;
        mk_res.kind         = KIND_MARK;
        mk_res.channel      = chan_reg[5:0];
        mk_res.pipe_or_type = rtype;
        mk_res.mark_id      = low;
        mk_res.start_time   = clk_new;
        mk_res.duration     = 64'd1;
        mk_res.end_run_open = eopen_new;
        mk_res.last         = 1'b1;
    end

    // output and pending beat selection
    assign out_free = !out_valid_reg || !out_stall;
    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        out_load        = 1'b0;
        out_data        = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (cmd.mark_emit)
        begin
            out_load = 1'b1;
            out_data = mk_res;
        end
        else if (cmd.p_eval && close_iv)
        begin
            pend_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                out_load = 1'b1;
                out_data.last = 1'b0;
            end
        end
        else if (cmd.flush)
        begin
            out_load = 1'b1;
            out_data.last = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= out_data;
        if (cmd.p_eval && close_iv)
            pend_reg <= iv_res;
    end

    // status
    always_comb
    begin
        sts.clr_last   = (clr_cnt_reg == PW'(DEPTH - 1));
        sts.busy_ok    = (rtype == TYPE_BUSY) && (32'(ctype_reg) < CORE_TYPES)
                         && (32'(chan_reg) < CHANNELS);
        sts.mark_ok    = ((rtype <= TYPE_MARK_MAX) || (rtype == TYPE_MARK_ALT))
                         && (32'(chan_reg) < CHANNELS);
        sts.p_last     = (p_reg == PIPE_W'(PIPES - 1));
        sts.need_emit  = close_iv;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

FILE: design/pipe_busy_trace_interval_decoder.sv
// Pipe busy trace interval decoder, top level.
// Input channel: one trace record per beat (core_id, core_type, info_word,
// cycle_delta), taken when in_valid is high and in_stall is low.
// Output channel: result beats (kind, channel, pipe_or_type, mark_id,
// start_time, duration, end_run_open, last), taken when out_valid is high
// and out_stall is low; last marks the final beat of a record.
// A mark record reads its channel clock, then updates it and loads the
// output register; no new record is taken until it is back in idle.
// A busy record walks its pipes one at a time, each through a read state
// and an evaluate state on the single port of the pipe start memory, and
// then a flush state. Dropped and ignored records return from the
// clock-read state straight to idle.
// Closed intervals pass through a one-beat holding register so that the
// last flag can be set; a mark waits on out_stall while the output register
// is full, and an interval waits while both registers are full.
// After reset the block clears its channel clock and pipe start memories
// in a single clearing pass and holds in_stall high during that pass.
module pipe_busy_trace_interval_decoder #(
    parameter int CHANNELS   = 64,
    parameter int PIPES      = 12,
    parameter int CORE_TYPES = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   core_id,
    input  logic [1:0]   core_type,
    input  logic [15:0]  info_word,
    input  logic [31:0]  cycle_delta,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         kind,
    output logic [5:0]   channel,
    output logic [3:0]   pipe_or_type,
    output logic [11:0]  mark_id,
    output logic [63:0]  start_time,
    output logic [63:0]  duration,
    output logic         end_run_open,
    output logic         last
);
    import pbtid_pkg::*;
`include "pipe_busy_trace_interval_decoder_defines.svh"

    cmd_t cmd;
    sts_t sts;
    res_t res;

    // controller
    pbtid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    pbtid_dp #(
        .CHANNELS   (CHANNELS),
        .PIPES      (PIPES),
        .CORE_TYPES (CORE_TYPES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .core_id     (core_id),
        .core_type   (core_type),
        .info_word   (info_word),
        .cycle_delta (cycle_delta),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_res     (res)
    );

    assign kind         = res.kind;
    assign channel      = res.channel;
    assign pipe_or_type = res.pipe_or_type;
    assign mark_id      = res.mark_id;
    assign start_time   = res.start_time;
    assign duration     = res.duration;
    assign end_run_open = res.end_run_open;
    assign last         = res.last;

    // checks
    `PBTID_ASSERT_NOW(a_no_accept_with_pending, clk, rst_n, in_valid && !in_stall, !sts.pend_valid)
    `PBTID_ASSERT_NOW(a_flush_has_room, clk, rst_n, cmd.flush, sts.out_free && sts.pend_valid)
    `PBTID_ASSERT_NOW(a_no_accept_while_clearing, clk, rst_n, cmd.clr, in_stall)
    `PBTID_ASSERT_NEXT(a_emit_sets_valid, clk, rst_n, cmd.mark_emit || cmd.flush, out_valid)

endmodule
